/* rtl/plm_pkg.sv */
`timescale 1ns / 1ps

package plm_pkg;

    // Default sizing of the list.
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths of the stream beats.
    localparam int OP_W   = 2;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    // Packed beat widths, filled up to whole bytes.
    localparam int S_DATA_W = ((OP_W + POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + VAL_W + CNT_W + 7) / 8) * 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Commands from the sequencer to the free-slot stack.
    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } stk_cmd_t;

endpackage

/* rtl/plm_node_ram.sv */
`timescale 1ns / 1ps

module plm_node_ram
    import plm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int WORD_W   = DEF_DATA_WIDTH + $clog2(DEF_CAPACITY)
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic [WORD_W-1:0]           rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic [WORD_W-1:0]           wr_data
);

    // Node storage: entry value in the upper bits, next-slot link below.
    logic [WORD_W-1:0] mem [CAPACITY];

    // One write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/plm_free_stack.sv */
`timescale 1ns / 1ps

module plm_free_stack
    import plm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stk_cmd_t                    cmd,
    input  logic [$clog2(CAPACITY)-1:0] push_slot,
    output logic [$clog2(CAPACITY)-1:0] pop_slot
);

    localparam int SW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    logic [SW-1:0] mem [CAPACITY];
    logic [SW-1:0] rd_data_reg;
    logic [LW-1:0] top_reg;
    logic [LW-1:0] top_next;
    logic [LW-1:0] low_reg;
    logic [LW-1:0] low_next;
    logic [LW-1:0] top_m1;

    assign top_m1 = top_reg - LW'(1);

    // Entries below the low-water mark were never written and stand for
    // their own index, so the top entry is served from the mark itself.
    assign pop_slot = (top_reg == low_reg) ? top_m1[SW-1:0] : rd_data_reg;

    // Stack pointer and low-water mark.
    always_comb begin
        top_next = top_reg;
        low_next = low_reg;
        if (cmd.pop) begin
            top_next = top_m1;
            if (top_reg == low_reg) begin
                low_next = top_m1;
            end
        end else if (cmd.push) begin
            top_next = top_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= LW'(CAPACITY);
            low_reg <= LW'(CAPACITY);
        end else begin
            top_reg <= top_next;
            low_reg <= low_next;
        end
    end

    // Push writes at the current top.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[top_reg[SW-1:0]] <= push_slot;
        end
    end

    // Registered read of the top entry ahead of a pop.
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[top_m1[SW-1:0]];
        end
    end

endmodule

/* rtl/positional_linked_list_top.sv */
`timescale 1ns / 1ps
// A rejected operation and an insert at the head do not walk; a read walks to rank k, a remove
// to rank k, and an insert after the entry at rank k walks to that entry. A new operation is
// taken only once the last result has gone into the output register, and the walk follows one
// link per cycle through the node memory's single read port.
// Reset (aresetn low, synchronous) empties the list and frees every slot at once.

module positional_linked_list_top
    import plm_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // operation [1:0], position [11:2], value [43:12], zero fill above
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status [1:0], read_value [33:2], entry_count [44:34], zero fill above
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SW     = $clog2(CAPACITY);
    localparam int LW     = $clog2(CAPACITY + 1);
    localparam int WORD_W = DATA_WIDTH + SW;
    localparam int CW     = (LW > POS_W) ? LW : POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_WALK     = 3'd2;
    localparam logic [2:0] S_INS_WR   = 3'd3;
    localparam logic [2:0] S_INS_LINK = 3'd4;
    localparam logic [2:0] S_REM_WR   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [SW-1:0]         head_reg, head_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [SW-1:0]         cur_reg, cur_next;
    logic [SW-1:0]         prev_reg, prev_next;
    logic [DATA_WIDTH-1:0] prev_val_reg, prev_val_next;
    logic [POS_W-1:0]      rank_reg, rank_next;
    logic [POS_W-1:0]      target_reg, target_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [VAL_W-1:0]      rd_val_reg, rd_val_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic                  node_rd_en;
    logic [SW-1:0]         node_rd_addr;
    logic [WORD_W-1:0]     node_rd_data;
    logic                  node_wr_en;
    logic [SW-1:0]         node_wr_addr;
    logic [WORD_W-1:0]     node_wr_data;
    logic [SW-1:0]         rd_link;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [63:0]           rd_ext;
    logic [VAL_W-1:0]      rd_sext;

    stk_cmd_t              stk_cmd;
    logic [SW-1:0]         push_slot;
    logic [SW-1:0]         pop_slot;

    logic [CW-1:0]         pos_x;
    logic [CW-1:0]         len_x;
    logic [CW-1:0]         len_m1;

    plm_node_ram #(
        .CAPACITY (CAPACITY),
        .WORD_W   (WORD_W)
    ) u_node_ram (
        .aclk    (aclk),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data)
    );

    plm_free_stack #(
        .CAPACITY (CAPACITY)
    ) u_free_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (stk_cmd),
        .push_slot (push_slot),
        .pop_slot  (pop_slot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Fields of the node word last read.
    assign rd_link  = node_rd_data[SW-1:0];
    assign rd_value = node_rd_data[WORD_W-1:SW];
    assign rd_ext   = 64'(rd_value);

    // Sign-extend the stored entry from its own width to the output width.
    always_comb begin
        for (int i = 0; i < VAL_W; i++) begin
            rd_sext[i] = (i < DATA_WIDTH) ? rd_ext[i] : rd_ext[DATA_WIDTH-1];
        end
    end

    // Rank and length compared at a common width.
    assign pos_x  = CW'(pos_reg);
    assign len_x  = CW'(len_reg);
    assign len_m1 = len_x - CW'(1);

    // Operation sequencer.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        head_next     = head_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_val_next = prev_val_reg;
        rank_next     = rank_reg;
        target_next   = target_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        rd_val_next   = rd_val_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        node_rd_en    = 1'b0;
        node_rd_addr  = head_reg;
        node_wr_en    = 1'b0;
        node_wr_addr  = cur_reg;
        node_wr_data  = node_rd_data;
        stk_cmd       = '0;
        push_slot     = cur_reg;

        // A taken result frees the output register.
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[OP_W-1:0];
                    pos_next   = s_tdata[OP_W+POS_W-1:OP_W];
                    val_next   = s_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];
                    state_next = S_CHECK;
                end
            end

            // Range checks; start the walk at the head.
            S_CHECK: begin
                rd_val_next = '0;
                status_next = ST_DONE;
                node_rd_en  = 1'b1;
                cur_next    = head_reg;
                rank_next   = '0;
                case (op_reg)
                    OP_INSERT: begin
                        if (pos_x > len_x) begin
                            status_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end else if (len_reg == LW'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end else begin
                            stk_cmd.rd  = 1'b1;
                            target_next = pos_reg - POS_W'(1);
                            state_next  = (pos_reg == '0) ? S_INS_WR : S_WALK;
                        end
                    end
                    OP_REMOVE: begin
                        if (len_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end else if (pos_x >= len_x) begin
                            status_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end else begin
                            target_next = pos_reg;
                            state_next  = S_WALK;
                        end
                    end
                    OP_READ: begin
                        if (len_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end else begin
                            target_next = (pos_x < len_x) ? pos_reg : len_m1[POS_W-1:0];
                            state_next  = S_WALK;
                        end
                    end
                    default: begin
                        status_next = ST_RANGE;
                        state_next  = S_FINISH;
                    end
                endcase
            end

            // One link per cycle: the read data addresses the next read.
            S_WALK: begin
                if (rank_reg == target_reg) begin
                    case (op_reg)
                        OP_INSERT: state_next = S_INS_WR;
                        OP_REMOVE: state_next = S_REM_WR;
                        default: begin
                            rd_val_next = rd_sext;
                            state_next  = S_FINISH;
                        end
                    endcase
                end else begin
                    prev_next     = cur_reg;
                    prev_val_next = rd_value;
                    node_rd_en    = 1'b1;
                    node_rd_addr  = rd_link;
                    cur_next      = rd_link;
                    rank_next     = rank_reg + POS_W'(1);
                end
            end

            // Take a free slot and write the new node into it.
            S_INS_WR: begin
                stk_cmd.pop  = 1'b1;
                slot_next    = pop_slot;
                node_wr_en   = 1'b1;
                node_wr_addr = pop_slot;
                node_wr_data = {DATA_WIDTH'(val_reg),
                                (pos_reg == '0) ? head_reg : rd_link};
                len_next     = len_reg + LW'(1);
                if (pos_reg == '0) begin
                    head_next  = pop_slot;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_INS_LINK;
                end
            end

            // Point the predecessor at the new node.
            S_INS_LINK: begin
                node_wr_en   = 1'b1;
                node_wr_addr = cur_reg;
                node_wr_data = {rd_value, slot_reg};
                state_next   = S_FINISH;
            end

            // Unlink the node and return its slot to the stack.
            S_REM_WR: begin
                stk_cmd.push = 1'b1;
                push_slot    = cur_reg;
                len_next     = len_reg - LW'(1);
                if (pos_reg == '0) begin
                    head_next = rd_link;
                end else begin
                    node_wr_en   = 1'b1;
                    node_wr_addr = prev_reg;
                    node_wr_data = {prev_val_reg, rd_link};
                end
                state_next = S_FINISH;
            end

            // Hand the result to the output register once it is free.
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({CNT_W'(len_reg), rd_val_reg, status_reg});
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_val_reg <= prev_val_next;
        rank_reg     <= rank_next;
        target_reg   <= target_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        rd_val_reg   <= rd_val_next;
        m_data_reg   <= m_data_next;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import plm_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    // Operation code that the block does not define.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [CNT_W-1:0]  entry_count;
    } list_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Model of the list contents, head first, and the results still to come.
    logic [VAL_W-1:0] list_model[$];
    list_result_t     pending_results[$];

    int mismatch_count = 0;
    bit gaps_on        = 1'b1;

    positional_linked_list_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Idle cycles that one side inserts before its next beat.
    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(6, 0)) : 0;
    endfunction

    // Apply one operation to the list model and return the result it gives.
    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] val);
        list_result_t res;
        int           len;
        int           rank;
        len            = list_model.size();
        rank           = int'(pos);
        res.status     = ST_DONE;
        res.read_value = '0;
        case (op)
            OP_INSERT: begin
                // The rank test comes before the full test.
                if (rank > len) begin
                    res.status = ST_RANGE;
                end else if (len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_model.insert(rank, val);
                end
            end
            OP_REMOVE: begin
                if (len == 0) begin
                    res.status = ST_EMPTY;
                end else if (rank >= len) begin
                    res.status = ST_RANGE;
                end else begin
                    list_model.delete(rank);
                end
            end
            OP_READ: begin
                // A read past the end returns the last entry.
                if (len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = list_model[(rank < len) ? rank : len - 1];
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        res.entry_count = CNT_W'(list_model.size());
        return res;
    endfunction

    // Send one operation beat and record the result it should give.
    task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({val, pos, op});
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    // Hold the sender until every outstanding result has arrived.
    task automatic wait_drain();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
        end
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, then compare each beat with the oldest expectation.
    initial begin
        int           stall;
        list_result_t got;
        list_result_t want;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.status      = m_tdata[STAT_W-1:0];
            got.read_value  = m_tdata[STAT_W +: VAL_W];
            got.entry_count = m_tdata[STAT_W + VAL_W +: CNT_W];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result beat: status %0d value %h count %0d",
                             got.status, got.read_value, got.entry_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.read_value != want.read_value ||
                    got.entry_count != want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: expected status %0d value %h count %0d,",
                                 want.status, want.read_value, want.entry_count);
                        $display("          got status %0d value %h count %0d",
                                 got.status, got.read_value, got.entry_count);
                    end
                end
            end
        end
    end

    // Every operation on an empty list, and the undefined operation code.
    task automatic test_empty_list();
        send_op(OP_READ, 10'd0, 32'h0000_0000);
        send_op(OP_READ, 10'd1023, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 10'd0, 32'h0000_0000);
        send_op(OP_REMOVE, 10'd1023, 32'h0000_0000);
        send_op(OP_INSERT, 10'd1, 32'h1234_5678);
        send_op(OP_UNUSED, 10'd0, 32'h0000_0000);
    endtask

    // Edits at the head, the middle and the tail, with extreme values.
    task automatic test_directed_edits();
        send_op(OP_INSERT, 10'd0, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 10'd1, 32'h8000_0000);
        send_op(OP_INSERT, 10'd0, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 10'd3, 32'h0000_0000);
        send_op(OP_INSERT, 10'd5, 32'h5555_5555);
        send_op(OP_INSERT, 10'd2, 32'hAAAA_AAAA);
        for (int i = 0; i < 5; i++) begin
            send_op(OP_READ, POS_W'(i), 32'h0000_0000);
        end
        send_op(OP_READ, 10'd5, 32'h0000_0000);
        send_op(OP_READ, 10'd1023, 32'hFFFF_FFFF);
        send_op(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 10'd4, 32'h0000_0000);
        send_op(OP_REMOVE, 10'd1, 32'h0000_0000);
        send_op(OP_REMOVE, 10'd0, 32'h0000_0000);
        send_op(OP_REMOVE, 10'd2, 32'h0000_0000);
        send_op(OP_READ, 10'd1, 32'h0000_0000);
        wait_drain();
    endtask

    // Random operations that keep the list short, with some ranks out of range.
    task automatic test_random_ops(int count);
        int               len;
        int               pick;
        int               ins_share;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        for (int n = 0; n < count; n++) begin
            // Every 64 operations, choose at random whether the next stretch has idle cycles.
            if (n % 64 == 0) begin
                gaps_on = ($urandom_range(3, 0) != 0);
            end
            if (n == count / 2) begin
                wait_drain();
            end
            len       = list_model.size();
            ins_share = (len > 48) ? 20 : 45;
            pick      = $urandom_range(99, 0);
            if (pick < ins_share) begin
                op = OP_INSERT;
            end else if (pick < ins_share + 30) begin
                op = OP_REMOVE;
            end else if (pick < 95) begin
                op = OP_READ;
            end else begin
                op = OP_UNUSED;
            end
            if ($urandom_range(9, 0) < 2) begin
                pos = POS_W'($urandom_range(1023, 0));
            end else if (op == OP_INSERT) begin
                pos = POS_W'($urandom_range(len, 0));
            end else begin
                pos = (len == 0) ? '0 : POS_W'($urandom_range(len - 1, 0));
            end
            case ($urandom_range(15, 0))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0000_0000;
                3:       val = 32'hFFFF_FFFF;
                default: val = $urandom();
            endcase
            send_op(op, pos, val);
        end
        gaps_on = 1'b1;
    endtask

    // Stimulus sequence and end of run.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_directed_edits();
        test_random_ops(555);

        wait_drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
